// ===== src/dmadv_pkg.sv =====
// Shared types and constants for the DMA descriptor validator.
// Used by dmadv_screen and dma_descriptor_validator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmadv_pkg;

   // Field widths fixed by the descriptor format
   localparam int OP_W    = 8;
   localparam int VER_W   = 16;
   localparam int FLAG_W  = 8;
   localparam int LEN_W   = 32;
   localparam int ADDR_W  = 64;
   localparam int CRC_W   = 32;
   localparam int RSV_W   = 64;
   localparam int TMO_W   = 32;
   localparam int TAG_W   = 16;
   localparam int COOKIE_W = 64;
   localparam int STAMP_W = 64;
   localparam int EK_W    = 4;
   localparam int OPS_W   = 2;   // opcode bits kept once the opcode is known valid

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TIMEOUT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TRANSFER = 1'd1;

   // Register reset values
   localparam logic [TMO_W-1:0] MAX_TIMEOUT_RST  = 32'd60000;
   localparam logic [LEN_W-1:0] MAX_TRANSFER_RST = 32'h0100_0000;

   // Opcodes and flags
   localparam logic [OP_W-1:0] OPC_NOP  = 8'd0;
   localparam logic [OP_W-1:0] OPC_COPY = 8'd1;
   localparam logic [OP_W-1:0] OPC_FILL = 8'd2;
   localparam logic [OP_W-1:0] OPC_CRC  = 8'd3;
   localparam int FLAG_VERIFY_BIT = 0;
   localparam logic [VER_W-1:0] GOOD_VERSION = 16'd1;

   // Error kinds
   localparam logic [EK_W-1:0] EK_NONE     = 4'd0;
   localparam logic [EK_W-1:0] EK_VERSION  = 4'd1;
   localparam logic [EK_W-1:0] EK_OPCODE   = 4'd2;
   localparam logic [EK_W-1:0] EK_FLAGS    = 4'd3;
   localparam logic [EK_W-1:0] EK_RESERVED = 4'd4;
   localparam logic [EK_W-1:0] EK_TIMEOUT  = 4'd5;
   localparam logic [EK_W-1:0] EK_LENGTH   = 4'd6;
   localparam logic [EK_W-1:0] EK_ADDRESS  = 4'd7;
   localparam logic [EK_W-1:0] EK_OVERFLOW = 4'd8;

   // Outcome of the first-stage screening of a descriptor
   typedef struct packed {
      logic            settled;    // error kind already final
      logic [EK_W-1:0] early_err;
      logic [OPS_W-1:0] op;
      logic            src_zero;
      logic            dst_zero;
   } screen_type;

endpackage

`default_nettype wire

// ===== src/dmadv_screen.sv =====
// First-stage screening: header, flag, reserved, timeout and length checks, and the no-op address check.
// Depends on dmadv_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module dmadv_screen (
   input  wire logic [dmadv_pkg::OP_W-1:0]   op_code,
   input  wire logic [dmadv_pkg::VER_W-1:0]  desc_version,
   input  wire logic [dmadv_pkg::FLAG_W-1:0] op_flags,
   input  wire logic [dmadv_pkg::LEN_W-1:0]  xfer_length,
   input  wire logic [dmadv_pkg::ADDR_W-1:0] src_addr,
   input  wire logic [dmadv_pkg::ADDR_W-1:0] dst_addr,
   input  wire logic [dmadv_pkg::CRC_W-1:0]  crc_expected,
   input  wire logic [dmadv_pkg::RSV_W-1:0]  reserved_bits,
   input  wire logic [dmadv_pkg::TMO_W-1:0]  timeout_value,
   input  wire logic [dmadv_pkg::TMO_W-1:0]  max_timeout,
   input  wire logic [dmadv_pkg::LEN_W-1:0]  max_transfer,
   output dmadv_pkg::screen_type              screen,
   output logic [dmadv_pkg::LEN_W-1:0]        len_m1
);

   logic is_crc;
   logic is_nop;
   logic flags_bad;
   logic crc_bad;
   logic len_bad;

   always_comb begin
      is_crc    = (op_code == dmadv_pkg::OPC_CRC);
      is_nop    = (op_code == dmadv_pkg::OPC_NOP);
      flags_bad = is_crc ? (|op_flags[dmadv_pkg::FLAG_W-1:1]) : (|op_flags);
      crc_bad   = !(is_crc && op_flags[dmadv_pkg::FLAG_VERIFY_BIT]) && (|crc_expected);
      len_bad   = (xfer_length == '0) || (xfer_length > max_transfer);
      len_m1    = xfer_length - dmadv_pkg::LEN_W'(1);

      screen.op       = op_code[dmadv_pkg::OPS_W-1:0];
      screen.src_zero = (src_addr == '0);
      screen.dst_zero = (dst_addr == '0);
      screen.settled  = 1'b1;

      if (desc_version != dmadv_pkg::GOOD_VERSION) begin
         screen.early_err = dmadv_pkg::EK_VERSION;
      end else if (op_code > dmadv_pkg::OPC_CRC) begin
         screen.early_err = dmadv_pkg::EK_OPCODE;
      end else if (flags_bad) begin
         screen.early_err = dmadv_pkg::EK_FLAGS;
      end else if (crc_bad || (|reserved_bits)) begin
         screen.early_err = dmadv_pkg::EK_RESERVED;
      end else if (timeout_value > max_timeout) begin
         screen.early_err = dmadv_pkg::EK_TIMEOUT;
      end else if (is_nop) begin
         if (xfer_length != '0) begin
            screen.early_err = dmadv_pkg::EK_LENGTH;
         end else if (!(screen.src_zero && screen.dst_zero)) begin
            screen.early_err = dmadv_pkg::EK_ADDRESS;
         end else begin
            screen.early_err = dmadv_pkg::EK_NONE;
         end
      end else if (len_bad) begin
         screen.early_err = dmadv_pkg::EK_LENGTH;
      end else begin
         // address checks still to come
         screen.early_err = dmadv_pkg::EK_NONE;
         screen.settled   = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== src/dma_descriptor_validator.sv =====
// DMA descriptor validator top level: three-stage checking pipeline and registers.
// Depends on dmadv_pkg and dmadv_screen.
`timescale 1ns / 1ps
`default_nettype none

// Validates one command descriptor per cycle and returns one completion item
// for each. Stage one screens the header, flags, reserved words, timeout and
// length; stage two forms the last byte address of each range with a 64-bit
// add and carry; the output stage compares the ranges for overlap and picks
// the first failing check. Throughput is one item per cycle while rsp_ready
// is high; a stall on rsp_ready backs up through the stages without loss.
// Configuration is written with csr_write_en and takes effect for items
// accepted afterwards; write only while the block is idle.

module dma_descriptor_validator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // descriptor channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [dmadv_pkg::OP_W-1:0]          req_op_code,
   input  wire logic [dmadv_pkg::VER_W-1:0]         req_desc_version,
   input  wire logic [dmadv_pkg::FLAG_W-1:0]        req_op_flags,
   input  wire logic [dmadv_pkg::LEN_W-1:0]         req_xfer_length,
   input  wire logic [dmadv_pkg::ADDR_W-1:0]        req_src_addr,
   input  wire logic [dmadv_pkg::ADDR_W-1:0]        req_dst_addr,
   input  wire logic [dmadv_pkg::CRC_W-1:0]         req_crc_expected,
   input  wire logic [dmadv_pkg::RSV_W-1:0]         req_reserved_bits,
   input  wire logic [dmadv_pkg::TMO_W-1:0]         req_timeout_value,
   input  wire logic [dmadv_pkg::TAG_W-1:0]         req_cmd_tag,
   input  wire logic [dmadv_pkg::COOKIE_W-1:0]      req_cookie_in,
   input  wire logic [dmadv_pkg::STAMP_W-1:0]       req_time_stamp,
   // completion channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [dmadv_pkg::TAG_W-1:0]              rsp_done_tag,
   output logic                                     rsp_status_flag,
   output logic [dmadv_pkg::EK_W-1:0]               rsp_error_kind,
   output logic [dmadv_pkg::COOKIE_W-1:0]           rsp_cookie_out,
   output logic [dmadv_pkg::STAMP_W-1:0]            rsp_stamp_out,
   // configuration
   input  wire logic                                csr_write_en,
   input  wire logic [dmadv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dmadv_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // configuration registers
   logic [dmadv_pkg::TMO_W-1:0] max_timeout_ff;
   logic [dmadv_pkg::LEN_W-1:0] max_transfer_ff;

   // stage one
   logic                              s1_valid_ff;
   dmadv_pkg::screen_type             s1_screen_ff;
   dmadv_pkg::screen_type             s1_screen_in;
   logic [dmadv_pkg::LEN_W-1:0]       s1_len_m1_ff;
   logic [dmadv_pkg::LEN_W-1:0]       s1_len_m1_in;
   logic [dmadv_pkg::ADDR_W-1:0]      s1_src_ff;
   logic [dmadv_pkg::ADDR_W-1:0]      s1_dst_ff;
   logic [dmadv_pkg::TAG_W-1:0]       s1_tag_ff;
   logic [dmadv_pkg::COOKIE_W-1:0]    s1_cookie_ff;
   logic [dmadv_pkg::STAMP_W-1:0]     s1_stamp_ff;

   // stage two
   logic                              s2_valid_ff;
   dmadv_pkg::screen_type             s2_screen_ff;
   logic [dmadv_pkg::ADDR_W-1:0]      s2_src_ff;
   logic [dmadv_pkg::ADDR_W-1:0]      s2_dst_ff;
   logic [dmadv_pkg::ADDR_W-1:0]      s2_src_last_ff;
   logic [dmadv_pkg::ADDR_W-1:0]      s2_dst_last_ff;
   logic                              s2_src_wrap_ff;
   logic                              s2_dst_wrap_ff;
   logic [dmadv_pkg::ADDR_W:0]        s2_src_sum_in;
   logic [dmadv_pkg::ADDR_W:0]        s2_dst_sum_in;
   logic [dmadv_pkg::TAG_W-1:0]       s2_tag_ff;
   logic [dmadv_pkg::COOKIE_W-1:0]    s2_cookie_ff;
   logic [dmadv_pkg::STAMP_W-1:0]     s2_stamp_ff;

   // output stage
   logic                              out_valid_ff;
   logic [dmadv_pkg::EK_W-1:0]        out_err_ff;
   logic [dmadv_pkg::EK_W-1:0]        out_err_in;
   logic [dmadv_pkg::TAG_W-1:0]       out_tag_ff;
   logic [dmadv_pkg::COOKIE_W-1:0]    out_cookie_ff;
   logic [dmadv_pkg::STAMP_W-1:0]     out_stamp_ff;
   logic                              overlap;

   logic adv_out;
   logic adv_s2;
   logic adv_s1;
   logic req_fire;

   // a stage moves on when its successor is empty or moving on itself
   assign adv_out   = !out_valid_ff || rsp_ready;
   assign adv_s2    = !s2_valid_ff || adv_out;
   assign adv_s1    = !s1_valid_ff || adv_s2;
   assign req_ready = adv_s1;
   assign req_fire  = req_valid && req_ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_timeout_ff  <= dmadv_pkg::MAX_TIMEOUT_RST;
         max_transfer_ff <= dmadv_pkg::MAX_TRANSFER_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            dmadv_pkg::CSR_MAX_TIMEOUT:  max_timeout_ff  <= csr_write_data;
            dmadv_pkg::CSR_MAX_TRANSFER: max_transfer_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   dmadv_screen u_screen (
      .op_code       (req_op_code),
      .desc_version  (req_desc_version),
      .op_flags      (req_op_flags),
      .xfer_length   (req_xfer_length),
      .src_addr      (req_src_addr),
      .dst_addr      (req_dst_addr),
      .crc_expected  (req_crc_expected),
      .reserved_bits (req_reserved_bits),
      .timeout_value (req_timeout_value),
      .max_timeout   (max_timeout_ff),
      .max_transfer  (max_transfer_ff),
      .screen        (s1_screen_in),
      .len_m1        (s1_len_m1_in)
   );

   // stage one registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv_s1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_screen_ff <= s1_screen_in;
         s1_len_m1_ff <= s1_len_m1_in;
         s1_src_ff    <= req_src_addr;
         s1_dst_ff    <= req_dst_addr;
         s1_tag_ff    <= req_cmd_tag;
         s1_cookie_ff <= req_cookie_in;
         s1_stamp_ff  <= req_time_stamp;
      end
   end

   // stage two: last byte of each range, carry out marks a wrap
   assign s2_src_sum_in = {1'b0, s1_src_ff}
                        + (dmadv_pkg::ADDR_W + 1)'(s1_len_m1_ff);
   assign s2_dst_sum_in = {1'b0, s1_dst_ff}
                        + (dmadv_pkg::ADDR_W + 1)'(s1_len_m1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv_s2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s2 && s1_valid_ff) begin
         s2_screen_ff   <= s1_screen_ff;
         s2_src_ff      <= s1_src_ff;
         s2_dst_ff      <= s1_dst_ff;
         s2_src_last_ff <= s2_src_sum_in[dmadv_pkg::ADDR_W-1:0];
         s2_dst_last_ff <= s2_dst_sum_in[dmadv_pkg::ADDR_W-1:0];
         s2_src_wrap_ff <= s2_src_sum_in[dmadv_pkg::ADDR_W];
         s2_dst_wrap_ff <= s2_dst_sum_in[dmadv_pkg::ADDR_W];
         s2_tag_ff      <= s1_tag_ff;
         s2_cookie_ff   <= s1_cookie_ff;
         s2_stamp_ff    <= s1_stamp_ff;
      end
   end

   // output stage: overlap test and final choice of error kind
   always_comb begin
      overlap = (s2_src_ff <= s2_dst_last_ff) && (s2_dst_ff <= s2_src_last_ff);
      out_err_in = dmadv_pkg::EK_NONE;
      if (s2_screen_ff.settled) begin
         out_err_in = s2_screen_ff.early_err;
      end else begin
         case (s2_screen_ff.op)
            dmadv_pkg::OPC_COPY[dmadv_pkg::OPS_W-1:0]: begin
               if (s2_src_wrap_ff || s2_dst_wrap_ff) begin
                  out_err_in = dmadv_pkg::EK_OVERFLOW;
               end else if (s2_screen_ff.src_zero || s2_screen_ff.dst_zero || overlap) begin
                  out_err_in = dmadv_pkg::EK_ADDRESS;
               end
            end
            dmadv_pkg::OPC_FILL[dmadv_pkg::OPS_W-1:0]: begin
               if (s2_dst_wrap_ff) begin
                  out_err_in = dmadv_pkg::EK_OVERFLOW;
               end else if (s2_screen_ff.src_zero || s2_screen_ff.dst_zero) begin
                  out_err_in = dmadv_pkg::EK_ADDRESS;
               end
            end
            dmadv_pkg::OPC_CRC[dmadv_pkg::OPS_W-1:0]: begin
               if (s2_src_wrap_ff) begin
                  out_err_in = dmadv_pkg::EK_OVERFLOW;
               end else if (s2_screen_ff.src_zero || !s2_screen_ff.dst_zero) begin
                  out_err_in = dmadv_pkg::EK_ADDRESS;
               end
            end
            default: out_err_in = dmadv_pkg::EK_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv_out) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && s2_valid_ff) begin
         out_err_ff    <= out_err_in;
         out_tag_ff    <= s2_tag_ff;
         out_cookie_ff <= s2_cookie_ff;
         out_stamp_ff  <= s2_stamp_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_done_tag    = out_tag_ff;
   assign rsp_error_kind  = out_err_ff;
   assign rsp_status_flag = (out_err_ff != dmadv_pkg::EK_NONE);
   assign rsp_cookie_out  = out_cookie_ff;
   assign rsp_stamp_out   = out_stamp_ff;

   // an accepted item always lands in stage one
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item did not enter stage one");

   // a held stage keeps its item
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv_s2) |=> (s1_valid_ff && $stable(s1_tag_ff)))
      else $error("stage one lost its item during a stall");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !adv_out) |=> (s2_valid_ff && $stable(s2_tag_ff)))
      else $error("stage two lost its item during a stall");

   // error kind stays within the defined codes
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_kind <= dmadv_pkg::EK_OVERFLOW))
      else $error("error kind out of range");

   // an unsettled item only reaches the address checks for a data-moving opcode
   a_unsettled_op: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_screen_ff.settled)
         |-> (s2_screen_ff.op != dmadv_pkg::OPC_NOP[dmadv_pkg::OPS_W-1:0]))
      else $error("no-op item left unsettled by the screen");

endmodule

`default_nettype wire

// ===== tb/sv/tb_dma_descriptor_validator.sv =====
// Self-checking testbench for dma_descriptor_validator: directed and random descriptors,
// predicted completions compared field by field. Depends on dmadv_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_dma_descriptor_validator;

   localparam logic [dmadv_pkg::TMO_W-1:0]  RESET_MAX_TMO = 32'd60000;
   localparam logic [dmadv_pkg::LEN_W-1:0]  RESET_MAX_LEN = 32'h0100_0000;
   localparam logic [dmadv_pkg::ADDR_W-1:0] ADDR_TOP      = '1;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 250;

   typedef struct packed {
      logic [dmadv_pkg::OP_W-1:0]     op_code;
      logic [dmadv_pkg::VER_W-1:0]    desc_version;
      logic [dmadv_pkg::FLAG_W-1:0]   op_flags;
      logic [dmadv_pkg::LEN_W-1:0]    xfer_length;
      logic [dmadv_pkg::ADDR_W-1:0]   src_addr;
      logic [dmadv_pkg::ADDR_W-1:0]   dst_addr;
      logic [dmadv_pkg::CRC_W-1:0]    crc_expected;
      logic [dmadv_pkg::RSV_W-1:0]    reserved_bits;
      logic [dmadv_pkg::TMO_W-1:0]    timeout_value;
      logic [dmadv_pkg::TAG_W-1:0]    cmd_tag;
      logic [dmadv_pkg::COOKIE_W-1:0] cookie_in;
      logic [dmadv_pkg::STAMP_W-1:0]  time_stamp;
   } descriptor_type;

   typedef struct packed {
      logic [dmadv_pkg::TAG_W-1:0]    done_tag;
      logic                           status_flag;
      logic [dmadv_pkg::EK_W-1:0]     error_kind;
      logic [dmadv_pkg::COOKIE_W-1:0] cookie_out;
      logic [dmadv_pkg::STAMP_W-1:0]  stamp_out;
   } completion_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [dmadv_pkg::OP_W-1:0]     req_op_code;
   logic [dmadv_pkg::VER_W-1:0]    req_desc_version;
   logic [dmadv_pkg::FLAG_W-1:0]   req_op_flags;
   logic [dmadv_pkg::LEN_W-1:0]    req_xfer_length;
   logic [dmadv_pkg::ADDR_W-1:0]   req_src_addr;
   logic [dmadv_pkg::ADDR_W-1:0]   req_dst_addr;
   logic [dmadv_pkg::CRC_W-1:0]    req_crc_expected;
   logic [dmadv_pkg::RSV_W-1:0]    req_reserved_bits;
   logic [dmadv_pkg::TMO_W-1:0]    req_timeout_value;
   logic [dmadv_pkg::TAG_W-1:0]    req_cmd_tag;
   logic [dmadv_pkg::COOKIE_W-1:0] req_cookie_in;
   logic [dmadv_pkg::STAMP_W-1:0]  req_time_stamp;
   logic rsp_valid;
   logic rsp_ready;
   logic [dmadv_pkg::TAG_W-1:0]    rsp_done_tag;
   logic                           rsp_status_flag;
   logic [dmadv_pkg::EK_W-1:0]     rsp_error_kind;
   logic [dmadv_pkg::COOKIE_W-1:0] rsp_cookie_out;
   logic [dmadv_pkg::STAMP_W-1:0]  rsp_stamp_out;
   logic                             csr_write_en;
   logic [dmadv_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dmadv_pkg::CSR_DATA_W-1:0] csr_write_data;

   // Limits as the block should currently hold them
   logic [dmadv_pkg::TMO_W-1:0] cfg_max_tmo;
   logic [dmadv_pkg::LEN_W-1:0] cfg_max_len;

   completion_type pending_cpl[$];
   completion_type due_cpl;
   int  fault_count;
   int  quiet_cycles;
   logic send_idle_on;
   logic recv_idle_on;

   dma_descriptor_validator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op_code(req_op_code), .req_desc_version(req_desc_version),
      .req_op_flags(req_op_flags), .req_xfer_length(req_xfer_length),
      .req_src_addr(req_src_addr), .req_dst_addr(req_dst_addr),
      .req_crc_expected(req_crc_expected), .req_reserved_bits(req_reserved_bits),
      .req_timeout_value(req_timeout_value), .req_cmd_tag(req_cmd_tag),
      .req_cookie_in(req_cookie_in), .req_time_stamp(req_time_stamp),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_done_tag(rsp_done_tag), .rsp_status_flag(rsp_status_flag),
      .rsp_error_kind(rsp_error_kind), .rsp_cookie_out(rsp_cookie_out),
      .rsp_stamp_out(rsp_stamp_out),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 8);
      else return $urandom_range(20, 40);
   endfunction

   // Completion for one descriptor under the current limits; first failing check wins
   function automatic completion_type predict_cpl(descriptor_type d);
      completion_type c;
      logic [dmadv_pkg::EK_W-1:0]   kind;
      logic [dmadv_pkg::FLAG_W-1:0] flag_mask;
      logic [dmadv_pkg::ADDR_W:0]   src_last;
      logic [dmadv_pkg::ADDR_W:0]   dst_last;
      logic verify;
      logic overlap;
      verify = d.op_flags[dmadv_pkg::FLAG_VERIFY_BIT];
      flag_mask = '1;
      if (d.op_code == dmadv_pkg::OPC_CRC) flag_mask[dmadv_pkg::FLAG_VERIFY_BIT] = 1'b0;
      // carry out of bit 63 marks a range that runs past the top of the address space
      src_last = {1'b0, d.src_addr} + {33'd0, d.xfer_length} - 65'd1;
      dst_last = {1'b0, d.dst_addr} + {33'd0, d.xfer_length} - 65'd1;
      overlap = (d.src_addr <= dst_last[dmadv_pkg::ADDR_W-1:0])
             && (d.dst_addr <= src_last[dmadv_pkg::ADDR_W-1:0]);
      if (d.desc_version != dmadv_pkg::GOOD_VERSION) kind = dmadv_pkg::EK_VERSION;
      else if (d.op_code > dmadv_pkg::OPC_CRC) kind = dmadv_pkg::EK_OPCODE;
      else if ((d.op_flags & flag_mask) != '0) kind = dmadv_pkg::EK_FLAGS;
      else if (!(d.op_code == dmadv_pkg::OPC_CRC && verify) && d.crc_expected != '0)
         kind = dmadv_pkg::EK_RESERVED;
      else if (d.reserved_bits != '0) kind = dmadv_pkg::EK_RESERVED;
      else if (d.timeout_value > cfg_max_tmo) kind = dmadv_pkg::EK_TIMEOUT;
      else if (d.op_code == dmadv_pkg::OPC_NOP) begin
         if (d.xfer_length != '0) kind = dmadv_pkg::EK_LENGTH;
         else if (d.src_addr != '0 || d.dst_addr != '0) kind = dmadv_pkg::EK_ADDRESS;
         else kind = dmadv_pkg::EK_NONE;
      end else if (d.xfer_length == '0 || d.xfer_length > cfg_max_len) begin
         kind = dmadv_pkg::EK_LENGTH;
      end else if (d.op_code == dmadv_pkg::OPC_COPY) begin
         if (src_last[dmadv_pkg::ADDR_W] || dst_last[dmadv_pkg::ADDR_W])
            kind = dmadv_pkg::EK_OVERFLOW;
         else if (d.src_addr == '0 || d.dst_addr == '0 || overlap) kind = dmadv_pkg::EK_ADDRESS;
         else kind = dmadv_pkg::EK_NONE;
      end else if (d.op_code == dmadv_pkg::OPC_FILL) begin
         if (dst_last[dmadv_pkg::ADDR_W]) kind = dmadv_pkg::EK_OVERFLOW;
         else if (d.src_addr == '0 || d.dst_addr == '0) kind = dmadv_pkg::EK_ADDRESS;
         else kind = dmadv_pkg::EK_NONE;
      end else begin
         if (src_last[dmadv_pkg::ADDR_W]) kind = dmadv_pkg::EK_OVERFLOW;
         else if (d.src_addr == '0 || d.dst_addr != '0) kind = dmadv_pkg::EK_ADDRESS;
         else kind = dmadv_pkg::EK_NONE;
      end
      c.done_tag    = d.cmd_tag;
      c.status_flag = (kind != dmadv_pkg::EK_NONE);
      c.error_kind  = kind;
      c.cookie_out  = d.cookie_in;
      c.stamp_out   = d.time_stamp;
      return c;
   endfunction

   function automatic descriptor_type mk_desc(logic [dmadv_pkg::OP_W-1:0] op,
                                              logic [dmadv_pkg::VER_W-1:0] ver,
                                              logic [dmadv_pkg::FLAG_W-1:0] flg,
                                              logic [dmadv_pkg::LEN_W-1:0] len,
                                              logic [dmadv_pkg::ADDR_W-1:0] src,
                                              logic [dmadv_pkg::ADDR_W-1:0] dst,
                                              logic [dmadv_pkg::CRC_W-1:0] crc,
                                              logic [dmadv_pkg::RSV_W-1:0] rsv,
                                              logic [dmadv_pkg::TMO_W-1:0] tmo);
      descriptor_type d;
      d.op_code = op;
      d.desc_version = ver;
      d.op_flags = flg;
      d.xfer_length = len;
      d.src_addr = src;
      d.dst_addr = dst;
      d.crc_expected = crc;
      d.reserved_bits = rsv;
      d.timeout_value = tmo;
      d.cmd_tag = dmadv_pkg::TAG_W'($urandom);
      d.cookie_in = rand64();
      d.time_stamp = rand64();
      return d;
   endfunction

   function automatic logic [dmadv_pkg::ADDR_W-1:0] pick_addr(logic [dmadv_pkg::LEN_W-1:0] len);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ADDR_TOP - len + 1;    // last byte exactly at the top
         2: return ADDR_TOP - len + 2;    // one byte past the top
         3, 4: return rand64();
         default: return {32'd0, $urandom};
      endcase
   endfunction

   // Well-formed descriptor with random content, some broken on purpose, a few pure noise
   function automatic descriptor_type random_desc();
      descriptor_type d;
      d = mk_desc(dmadv_pkg::OP_W'(rand64()), dmadv_pkg::VER_W'(rand64()),
                  dmadv_pkg::FLAG_W'(rand64()), $urandom, rand64(), rand64(),
                  $urandom, rand64(), $urandom);
      if ($urandom_range(0, 19) == 0) return d;
      d.desc_version = dmadv_pkg::GOOD_VERSION;
      case ($urandom_range(0, 3))
         0: d.op_code = dmadv_pkg::OPC_NOP;
         1: d.op_code = dmadv_pkg::OPC_COPY;
         2: d.op_code = dmadv_pkg::OPC_FILL;
         default: d.op_code = dmadv_pkg::OPC_CRC;
      endcase
      d.op_flags = '0;
      d.crc_expected = '0;
      if (d.op_code == dmadv_pkg::OPC_CRC && $urandom_range(0, 1) == 1) begin
         d.op_flags[dmadv_pkg::FLAG_VERIFY_BIT] = 1'b1;
         if ($urandom_range(0, 3) != 0) d.crc_expected = $urandom;
      end
      d.reserved_bits = '0;
      case ($urandom_range(0, 5))
         0: d.timeout_value = '0;
         1: d.timeout_value = cfg_max_tmo;
         2: d.timeout_value = cfg_max_tmo + 1;
         default: d.timeout_value = $urandom_range(cfg_max_tmo, 0);
      endcase
      case ($urandom_range(0, 7))
         0: d.xfer_length = 1;
         1: d.xfer_length = cfg_max_len;
         2: d.xfer_length = cfg_max_len + 1;
         3: d.xfer_length = '0;
         4, 5: d.xfer_length = $urandom_range(1, 256);
         default: d.xfer_length = (cfg_max_len == '0) ? $urandom : $urandom_range(cfg_max_len, 1);
      endcase
      d.src_addr = pick_addr(d.xfer_length);
      d.dst_addr = pick_addr(d.xfer_length);
      if (d.op_code == dmadv_pkg::OPC_NOP) begin
         if ($urandom_range(0, 7) != 0) d.xfer_length = '0;
         if ($urandom_range(0, 7) != 0) d.src_addr = '0;
         if ($urandom_range(0, 7) != 0) d.dst_addr = '0;
      end else if (d.op_code == dmadv_pkg::OPC_CRC) begin
         if ($urandom_range(0, 7) != 0) d.dst_addr = '0;
      end else if (d.op_code == dmadv_pkg::OPC_COPY) begin
         // pull the two ranges onto each other, right at the touching boundaries
         case ($urandom_range(0, 5))
            0: d.dst_addr = d.src_addr;
            1: d.dst_addr = d.src_addr + d.xfer_length - $urandom_range(0, 1);
            2: d.dst_addr = d.src_addr - d.xfer_length + $urandom_range(0, 1);
            3: d.src_addr = d.dst_addr + d.xfer_length - $urandom_range(0, 1);
            default: ;
         endcase
      end
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 5))
            0: d.desc_version = dmadv_pkg::VER_W'($urandom);
            1: d.op_code = dmadv_pkg::OP_W'($urandom_range(4, 255));
            2: d.op_flags = d.op_flags ^ (8'd1 << $urandom_range(0, 7));
            3: d.crc_expected = $urandom;
            4: d.reserved_bits = 64'd1 << $urandom_range(0, 63);
            default: d.timeout_value = cfg_max_tmo + $urandom_range(1, 16);
         endcase
      end
      return d;
   endfunction

   // Present one item, hold it until accepted, then record its completion
   task automatic issue_desc(input descriptor_type d);
      int gap;
      gap = 0;
      if (send_idle_on && $urandom_range(0, 2) == 0) gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op_code       <= d.op_code;
      req_desc_version  <= d.desc_version;
      req_op_flags      <= d.op_flags;
      req_xfer_length   <= d.xfer_length;
      req_src_addr      <= d.src_addr;
      req_dst_addr      <= d.dst_addr;
      req_crc_expected  <= d.crc_expected;
      req_reserved_bits <= d.reserved_bits;
      req_timeout_value <= d.timeout_value;
      req_cmd_tag       <= d.cmd_tag;
      req_cookie_in     <= d.cookie_in;
      req_time_stamp    <= d.time_stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_cpl.push_back(predict_cpl(d));
   endtask

   // Drop valid and wait until every completion is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_cpl.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limits(input logic [dmadv_pkg::TMO_W-1:0] tmo,
                             input logic [dmadv_pkg::LEN_W-1:0] len);
      settle();
      csr_write_en   <= 1'b1;
      csr_index      <= dmadv_pkg::CSR_MAX_TIMEOUT;
      csr_write_data <= tmo;
      @(posedge clock);
      csr_index      <= dmadv_pkg::CSR_MAX_TRANSFER;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg_max_tmo = tmo;
      cfg_max_len = len;
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         fault_count++;
         $display("%0t %s: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Every check in priority order under the reset limits
   task automatic test_directed_checks();
      descriptor_type d;
      logic [dmadv_pkg::ADDR_W-1:0] near_top;
      near_top = ADDR_TOP - 64'd15;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      d = mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0, '0, '0);
      d.cmd_tag = '0;
      d.cookie_in = '0;
      d.time_stamp = '0;
      issue_desc(d);
      d = mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0, '0,
                  RESET_MAX_TMO);
      d.cmd_tag = '1;
      d.cookie_in = '1;
      d.time_stamp = '1;
      issue_desc(d);
      issue_desc(mk_desc(8'hFF, 16'd0, '0, '0, '0, '0, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0));
      issue_desc(mk_desc(8'd4, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0, '0, '0));
      issue_desc(mk_desc(8'hFF, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, 8'h01, '0, '0, '0,
                         '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_CRC, dmadv_pkg::GOOD_VERSION, 8'hFE, 32'd16,
                         64'h1000, '0, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, 8'h80, 32'd16,
                         64'h1000, 64'h2000, '0, '0, '0));
      // crc verify lets a nonzero expected crc through
      issue_desc(mk_desc(dmadv_pkg::OPC_CRC, dmadv_pkg::GOOD_VERSION, 8'h01, 32'd16,
                         64'h1000, '0, '1, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_FILL, dmadv_pkg::GOOD_VERSION, '0, 32'd16,
                         64'h1000, 64'h2000, 32'd1, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_CRC, dmadv_pkg::GOOD_VERSION, '0, 32'd16,
                         64'h1000, '0, 32'd1, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0,
                         64'h8000_0000_0000_0000, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0,
                         '0, RESET_MAX_TMO + 1));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, 32'd1, '0, '0,
                         '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, 64'd1, '0,
                         '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, '0, 64'h1000,
                         64'h2000, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, RESET_MAX_LEN + 1,
                         64'h1000_0000, 64'h2000_0000, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, RESET_MAX_LEN,
                         64'h1000_0000, 64'h2000_0000, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd16, near_top,
                         64'h1000, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd16, 64'h1000,
                         near_top + 1, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd16, 64'h1000,
                         64'h100F, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd16, 64'h1000,
                         64'h1010, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd16, '0,
                         64'h2000, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_FILL, dmadv_pkg::GOOD_VERSION, '0, 32'd16, 64'h1000,
                         near_top + 1, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_FILL, dmadv_pkg::GOOD_VERSION, '0, 32'd16, '0,
                         64'h2000, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_CRC, dmadv_pkg::GOOD_VERSION, '0, 32'd16, 64'h1000,
                         64'h2000, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_CRC, dmadv_pkg::GOOD_VERSION, '0, 32'd16,
                         near_top + 1, '0, '0, '0, '0));
   endtask

   // Zero, all-ones and single-unit limits
   task automatic test_limit_extremes();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      set_limits('0, '0);
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0,
                         '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0,
                         '0, 32'd1));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd1, 64'h10,
                         64'h20, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_CRC, dmadv_pkg::GOOD_VERSION, '0, 32'd1, 64'h10,
                         '0, '0, '0, '0));
      set_limits('1, '1);
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0,
                         '0, '1));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, '1, 64'd1,
                         64'h1_0000_0000, '0, '0, '1));
      issue_desc(mk_desc(dmadv_pkg::OPC_FILL, dmadv_pkg::GOOD_VERSION, '0, '1, 64'd5,
                         64'hFFFF_FFFF_0000_0001, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_FILL, dmadv_pkg::GOOD_VERSION, '0, '1, 64'd5,
                         64'hFFFF_FFFF_0000_0002, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_CRC, dmadv_pkg::GOOD_VERSION, 8'h01, '1, '0, '0,
                         '1, '0, '0));
      set_limits(32'd1, 32'd1);
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd1, 64'd5,
                         64'd6, '0, '0, 32'd1));
      issue_desc(mk_desc(dmadv_pkg::OPC_COPY, dmadv_pkg::GOOD_VERSION, '0, 32'd2, 64'd5,
                         64'd9, '0, '0, '0));
      issue_desc(mk_desc(dmadv_pkg::OPC_NOP, dmadv_pkg::GOOD_VERSION, '0, '0, '0, '0, '0,
                         '0, 32'd2));
   endtask

   // Random descriptors across several limit settings and idling patterns
   task automatic test_random_phases();
      int p;
      for (p = 0; p < 6; p++) begin
         case (p)
            0: set_limits(RESET_MAX_TMO, RESET_MAX_LEN);
            1: set_limits($urandom_range(1000, 100000), 32'd4096);
            2: set_limits('0, 32'd1);
            3: set_limits('1, '1);
            4: set_limits($urandom, $urandom);
            default: set_limits(32'd1, '0);
         endcase
         send_idle_on = (p != 0 && p != 3);
         recv_idle_on = (p != 0 && p != 2);
         repeat (PHASE_ITEMS) issue_desc(random_desc());
      end
   endtask

   // Bursts separated by full drains of the pipeline
   task automatic test_drain_pauses();
      set_limits(RESET_MAX_TMO, RESET_MAX_LEN);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      repeat (4) begin
         repeat ($urandom_range(10, 60)) issue_desc(random_desc());
         settle();
      end
   endtask

   // Completion side back-pressure
   initial begin : rsp_throttle
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            hold = idle_len() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cpl.size() == 0) begin
            fault_count++;
            $display("%0t completion with none outstanding: expected nothing, actual tag %h",
                     $time, rsp_done_tag);
         end else begin
            due_cpl = pending_cpl.pop_front();
            check_field("done_tag", 64'(due_cpl.done_tag), 64'(rsp_done_tag));
            check_field("status_flag", 64'(due_cpl.status_flag), 64'(rsp_status_flag));
            check_field("error_kind", 64'(due_cpl.error_kind), 64'(rsp_error_kind));
            check_field("cookie_out", due_cpl.cookie_out, rsp_cookie_out);
            check_field("stamp_out", due_cpl.stamp_out, rsp_stamp_out);
         end
      end
   end

   // Stop a hung run: count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op_code = '0;
      req_desc_version = '0;
      req_op_flags = '0;
      req_xfer_length = '0;
      req_src_addr = '0;
      req_dst_addr = '0;
      req_crc_expected = '0;
      req_reserved_bits = '0;
      req_timeout_value = '0;
      req_cmd_tag = '0;
      req_cookie_in = '0;
      req_time_stamp = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      cfg_max_tmo = RESET_MAX_TMO;
      cfg_max_len = RESET_MAX_LEN;
      fault_count = 0;
      quiet_cycles = 0;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_checks();
      test_limit_extremes();
      test_random_phases();
      test_drain_pauses();
      settle();
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
